[src/assert_macros.svh]
// assertion helper macros shared by the rtl
// expects a clock named clock and a synchronous active-high reset named reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
`define CHK_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`else
`define CHK_ALWAYS(lbl, expr, msg)
`define CHK_IMPLY(lbl, ante, cons, msg)
`endif
`endif

[src/tgr_pkg.sv]
// types, constants and helper functions for the touch gesture recognizer
// no dependencies
package tgr_pkg;

   localparam int NumRegions = 4;
   localparam int RegionIdxW = 2;
   localparam int FifoDepth = 4;
   localparam int FifoPtrW = 2;
   localparam int FifoCntW = 3;
   localparam logic [15:0] LongPressure = 16'd100;
   localparam logic [15:0] PollMax = 16'hFFFF;

   typedef enum logic [2:0] {
      EV_START = 3'd0,
      EV_UP    = 3'd1,
      EV_DOWN  = 3'd2,
      EV_LEFT  = 3'd3,
      EV_RIGHT = 3'd4,
      EV_SHORT = 3'd5,
      EV_LONG  = 3'd6,
      EV_END   = 3'd7
   } evt_code_type;

   typedef enum logic [2:0] {
      CSR_REGION_0     = 3'd0,
      CSR_REGION_1     = 3'd1,
      CSR_REGION_2     = 3'd2,
      CSR_REGION_3     = 3'd3,
      CSR_REGION_COUNT = 3'd4,
      CSR_LONG_POLLS   = 3'd5,
      CSR_MOVE_DELTA   = 3'd6,
      CSR_TOUCH_DELTA  = 3'd7
   } csr_addr_type;

   typedef struct packed {
      logic [15:0] y_high;
      logic [15:0] x_high;
      logic [15:0] y_low;
      logic [15:0] x_low;
   } region_type;

   typedef struct packed {
      logic                  last;
      logic [15:0]           pressure;
      logic [15:0]           y;
      logic [15:0]           x;
      logic [RegionIdxW-1:0] region;
      evt_code_type          code;
   } result_type;

   typedef struct packed {
      logic         hit;
      evt_code_type code;
   } cls_type;

   function automatic logic in_region(region_type rg, logic [15:0] x, logic [15:0] y);
      return (x >= rg.x_low) && (x < rg.x_high) && (y >= rg.y_low) && (y < rg.y_high);
   endfunction

   function automatic logic [15:0] abs_diff(logic [15:0] a, logic [15:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic cls_type classify(logic [15:0] x, logic [15:0] y,
                                        logic [15:0] sx, logic [15:0] sy,
                                        logic [15:0] move_delta,
                                        logic [15:0] touch_delta);
      cls_type res;
      res.hit = 1'b1;
      res.code = EV_SHORT;
      if ((y < sy) && ((sy - y) > move_delta)) begin
         res.code = EV_UP;
      end else if ((y > sy) && ((y - sy) > move_delta)) begin
         res.code = EV_DOWN;
      end else if ((x < sx) && ((sx - x) > move_delta)) begin
         res.code = EV_LEFT;
      end else if ((x > sx) && ((x - sx) > move_delta)) begin
         res.code = EV_RIGHT;
      end else if ((abs_diff(x, sx) < touch_delta) && (abs_diff(y, sy) < touch_delta)) begin
         res.code = EV_SHORT;
      end else begin
         res.hit = 1'b0;
      end
      return res;
   endfunction

endpackage

[src/touch_gesture_recognizer.sv]
// Touch gesture recognizer: one polled touch sample in, zero to two gesture events out.
// A sample is registered, evaluated against the gesture state and its
// events are pushed into a four-entry result queue. One sample per cycle is taken;
// events leave one per cycle while rsp_tready is high, so a run of samples that each
// cause one event flows at full rate, and the input stalls only while the queue has
// fewer than two free slots. Uses tgr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module touch_gesture_recognizer (
   input  logic        clock,
   input  logic        reset,
   // input samples
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // pos_x, pos_y, pressure
   // gesture events
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // event_code, region_index, event_x, event_y,
                                    // event_pressure, zero fill
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [63:0] csr_wdata
);

   // configuration registers
   tgr_pkg::region_type region_ff [tgr_pkg::NumRegions];
   logic [2:0]  region_count_ff;
   logic [15:0] long_polls_ff;
   logic [15:0] move_delta_ff;
   logic [15:0] touch_delta_ff;

   // input stage
   logic        in_valid_ff, in_valid_in;
   logic [15:0] in_x_ff, in_y_ff, in_p_ff;
   logic        advance;

   // gesture state
   logic                           press_ff, press_in;
   logic [tgr_pkg::RegionIdxW-1:0] act_ff, act_in;
   logic [15:0]                    start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [15:0]                    last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic                           moved_ff, moved_in, long_done_ff, long_done_in;
   logic [15:0]                    poll_ff, poll_in;

   // result queue
   tgr_pkg::result_type          fifo_mem_ff [tgr_pkg::FifoDepth];
   logic [tgr_pkg::FifoPtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [tgr_pkg::FifoCntW-1:0] cnt_ff, cnt_in;
   logic                         pop;

   // event assembly
   logic                           long_hit, sec_valid, found, leave;
   tgr_pkg::evt_code_type          sec_code;
   logic [tgr_pkg::RegionIdxW-1:0] sec_region, match_idx;
   tgr_pkg::cls_type               cls;
   tgr_pkg::result_type            ev0, ev1;
   logic [1:0]                     n_res;
   tgr_pkg::result_type            head;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tgr_pkg::NumRegions; i++) begin
            region_ff[i] <= '0;
         end
         region_count_ff <= 3'd0;
         long_polls_ff   <= 16'd36;
         move_delta_ff   <= 16'd120;
         touch_delta_ff  <= 16'd20;
      end else if (csr_we) begin
         unique case (tgr_pkg::csr_addr_type'(csr_addr))
            tgr_pkg::CSR_REGION_0, tgr_pkg::CSR_REGION_1,
            tgr_pkg::CSR_REGION_2, tgr_pkg::CSR_REGION_3: begin
               region_ff[csr_addr[tgr_pkg::RegionIdxW-1:0]] <= csr_wdata;
            end
            tgr_pkg::CSR_REGION_COUNT: region_count_ff <= csr_wdata[2:0];
            tgr_pkg::CSR_LONG_POLLS:   long_polls_ff   <= csr_wdata[15:0];
            tgr_pkg::CSR_MOVE_DELTA:   move_delta_ff   <= csr_wdata[15:0];
            tgr_pkg::CSR_TOUCH_DELTA:  touch_delta_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // input register
   assign advance    = in_valid_ff && (cnt_ff <= tgr_pkg::FifoCntW'(tgr_pkg::FifoDepth - 2));
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tready && req_tvalid) begin
         in_x_ff <= req_tdata[15:0];
         in_y_ff <= req_tdata[31:16];
         in_p_ff <= req_tdata[47:32];
      end
   end

   // first enabled region that holds the sample
   always_comb begin
      found = 1'b0;
      match_idx = '0;
      for (int i = tgr_pkg::NumRegions - 1; i >= 0; i--) begin
         if ((region_count_ff > 3'(i)) && tgr_pkg::in_region(region_ff[i], in_x_ff, in_y_ff)) begin
            found = 1'b1;
            match_idx = tgr_pkg::RegionIdxW'(i);
         end
      end
   end

   // gesture evaluation
   always_comb begin
      press_in     = press_ff;
      act_in       = act_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      moved_in     = moved_ff;
      long_done_in = long_done_ff;
      poll_in      = poll_ff;
      long_hit     = 1'b0;
      sec_valid    = 1'b0;
      sec_code     = tgr_pkg::EV_START;
      sec_region   = act_ff;
      leave        = (in_p_ff == 16'd0) ||
                     !tgr_pkg::in_region(region_ff[act_ff], in_x_ff, in_y_ff);
      cls          = tgr_pkg::classify(in_x_ff, in_y_ff, start_x_ff, start_y_ff,
                                       move_delta_ff, touch_delta_ff);
      if (advance) begin
         if (press_ff) begin
            poll_in  = (poll_ff == tgr_pkg::PollMax) ? poll_ff : poll_ff + 16'd1;
            long_hit = !moved_ff && !long_done_ff && (poll_in >= long_polls_ff);
            long_done_in = long_done_ff || long_hit;
            if (leave) begin
               press_in = 1'b0;
               if (moved_ff || long_done_in) begin
                  sec_valid = 1'b1;
                  sec_code  = tgr_pkg::EV_END;
               end else if (cls.hit && (cls.code == tgr_pkg::EV_SHORT)) begin
                  sec_valid = 1'b1;
                  sec_code  = tgr_pkg::EV_SHORT;
               end
            end else if (!long_done_in) begin
               last_x_in = in_x_ff;
               last_y_in = in_y_ff;
               if (cls.hit && (cls.code != tgr_pkg::EV_SHORT)) begin
                  sec_valid = 1'b1;
                  sec_code  = cls.code;
                  moved_in  = 1'b1;
                  if ((cls.code == tgr_pkg::EV_UP) || (cls.code == tgr_pkg::EV_DOWN)) begin
                     start_y_in = in_y_ff;
                  end else begin
                     start_x_in = in_x_ff;
                  end
               end
            end
         end else if ((in_p_ff != 16'd0) && found) begin
            press_in     = 1'b1;
            act_in       = match_idx;
            poll_in      = 16'd0;
            start_x_in   = in_x_ff;
            start_y_in   = in_y_ff;
            last_x_in    = in_x_ff;
            last_y_in    = in_y_ff;
            moved_in     = 1'b0;
            long_done_in = 1'b0;
            sec_valid    = 1'b1;
            sec_code     = tgr_pkg::EV_START;
            sec_region   = match_idx;
         end
      end
   end

   // result entries in delivery order
   always_comb begin
      ev1.code     = sec_code;
      ev1.region   = sec_region;
      ev1.x        = in_x_ff;
      ev1.y        = in_y_ff;
      ev1.pressure = in_p_ff;
      ev1.last     = 1'b1;
      if (long_hit) begin
         ev0.code     = tgr_pkg::EV_LONG;
         ev0.region   = act_ff;
         ev0.x        = last_x_ff;
         ev0.y        = last_y_ff;
         ev0.pressure = tgr_pkg::LongPressure;
         ev0.last     = !sec_valid;
      end else begin
         ev0 = ev1;
      end
      n_res = {1'b0, long_hit} + {1'b0, sec_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_ff     <= 1'b0;
         act_ff       <= '0;
         start_x_ff   <= 16'd0;
         start_y_ff   <= 16'd0;
         last_x_ff    <= 16'd0;
         last_y_ff    <= 16'd0;
         moved_ff     <= 1'b0;
         long_done_ff <= 1'b0;
         poll_ff      <= 16'd0;
      end else begin
         press_ff     <= press_in;
         act_ff       <= act_in;
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         moved_ff     <= moved_in;
         long_done_ff <= long_done_in;
         poll_ff      <= poll_in;
      end
   end

   // result queue
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (cnt_ff != '0);
   assign head       = fifo_mem_ff[rd_ptr_ff];
   assign rsp_tdata  = {3'b000, head.pressure, head.y, head.x, head.region, head.code};
   assign rsp_tlast  = head.last;
   assign cnt_in     = cnt_ff + tgr_pkg::FifoCntW'(n_res) - tgr_pkg::FifoCntW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + tgr_pkg::FifoPtrW'(n_res);
         rd_ptr_ff <= rd_ptr_ff + tgr_pkg::FifoPtrW'(pop);
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_res != 2'd0) begin
         fifo_mem_ff[wr_ptr_ff] <= ev0;
      end
      if (n_res == 2'd2) begin
         fifo_mem_ff[wr_ptr_ff + tgr_pkg::FifoPtrW'(1)] <= ev1;
      end
   end

   `CHK_ALWAYS(a_cnt_bound, cnt_ff <= tgr_pkg::FifoCntW'(tgr_pkg::FifoDepth), "result queue overflow")
   `CHK_IMPLY(a_room_for_two, advance, cnt_ff <= tgr_pkg::FifoCntW'(tgr_pkg::FifoDepth - 2), "sample taken without room")
   `CHK_IMPLY(a_pair_long_end, n_res == 2'd2, (ev0.code == tgr_pkg::EV_LONG) && (ev1.code == tgr_pkg::EV_END), "unexpected event pair")
   `CHK_IMPLY(a_no_push_idle, !advance, n_res == 2'd0, "event pushed without a sample")

endmodule
